// ----- hw/rtl/itq_pkg.sv -----
// Shared definitions for the indexed table query engine.
// Field widths, query kind codes, register map and reset values.
// No dependencies.
package itq_pkg;

  // Default table size
  localparam int ITQ_TABLE_DEPTH = 64;

  // Fixed field widths
  localparam int POS_W  = 7;
  localparam int WORD_W = 32;
  localparam int KIND_W = 2;

  // Stream payload widths (tdata padded to whole bytes)
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 40;

  // Configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  // Register indexes (byte address = 4 * index)
  localparam logic REG_USED_LENGTH = 1'b0;

  // used_length after reset
  localparam logic [POS_W-1:0] USED_LENGTH_RST = 7'd64;

  // Query kinds carried in tuser
  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_FIND  = 2'd2,
    KIND_RANGE = 2'd3
  } kind_t;

endpackage

// ----- hw/rtl/indexed_table_query_engine.sv -----
// Indexed table query engine: a table of signed words that is loaded, read, searched and
// dumped by range through one registered read port of a local memory. Depends on itq_pkg.
// Results: a bad load gives an error (a good load none); a read gives its word; a find
// gives the first matching position or zero; a range gives one word per cycle while the
// output is ready. One query at a time; input waits until its last result is registered.
// Sync active-low reset clears control and sets used_length to 64; table is not cleared.
module indexed_table_query_engine #(
  parameter int TABLE_DEPTH = itq_pkg::ITQ_TABLE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,

  // Query stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [6:0] first_position, [13:7] last_position, [45:14] data_value, [47:46] zero
  input  logic [itq_pkg::IN_TDATA_W-1:0] in_tdata,
  // [1:0] kind
  input  logic [itq_pkg::KIND_W-1:0]     in_tuser,

  // Result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [31:0] word_out, [38:32] found_position, [39] zero
  output logic [itq_pkg::OUT_TDATA_W-1:0] out_tdata,
  // [0] status
  output logic                           out_tuser,
  output logic                           out_tlast,

  // Configuration port
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [itq_pkg::CFG_AW-1:0]     cfg_paddr,
  input  logic [itq_pkg::CFG_DW-1:0]     cfg_pwdata,
  output logic [itq_pkg::CFG_DW-1:0]     cfg_prdata,
  output logic                           cfg_pready
);

  import itq_pkg::*;

  // Index width into the table, and a count width that holds the depth
  localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int DCW  = $clog2(TABLE_DEPTH + 1);
  localparam int LW   = (DCW > POS_W) ? DCW : POS_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ_OUT,
    S_FIND,
    S_FIND_OUT,
    S_RANGE,
    S_ERR
  } state_t;

  // Registers
  state_t                    state_r, state_nxt;
  logic [POS_W-1:0]          used_len_r;
  logic [LW-1:0]             rd_idx_r, rd_idx_nxt;
  logic [LW-1:0]             pend_idx_r, pend_idx_nxt;
  logic                      pend_r, pend_nxt;
  logic [LW-1:0]             last_idx_r, last_idx_nxt;
  logic signed [WORD_W-1:0]  v_r, v_nxt;
  logic [POS_W-1:0]          found_r, found_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic signed [WORD_W-1:0]  out_word_r, out_word_nxt;
  logic [POS_W-1:0]          out_found_r, out_found_nxt;
  logic                      out_status_r, out_status_nxt;
  logic                      out_last_r, out_last_nxt;

  // Table memory
  logic signed [WORD_W-1:0]  table_mem [TABLE_DEPTH];
  logic signed [WORD_W-1:0]  mem_q_r;
  logic                      rd_en, wr_en;
  logic [AW-1:0]             rd_addr, wr_addr;

  // Input field unpacking
  kind_t                     in_kind;
  logic [POS_W-1:0]          in_first;
  logic [POS_W-1:0]          in_last;
  logic signed [WORD_W-1:0]  in_value;

  logic [LW-1:0]             eff_len;
  logic [LW-1:0]             first_ext, last_ext;
  logic [LW-1:0]             first_m1, last_m1;
  logic                      first_ok, last_ok;
  logic                      in_xfer;
  logic                      out_free;
  logic                      issue;
  logic                      move;
  logic                      cfg_wr;

  assign in_kind  = kind_t'(in_tuser);
  assign in_first = in_tdata[POS_W-1:0];
  assign in_last  = in_tdata[2*POS_W-1:POS_W];
  assign in_value = in_tdata[2*POS_W+WORD_W-1:2*POS_W];

  // Effective length is the smaller of the register and the depth
  assign eff_len = (LW'(used_len_r) < LW'(TABLE_DEPTH)) ? LW'(used_len_r) : LW'(TABLE_DEPTH);

  // Position checks (1-based, within the effective length)
  assign first_ext = LW'(in_first);
  assign last_ext  = LW'(in_last);
  assign first_m1  = first_ext - 1'b1;
  assign last_m1   = last_ext - 1'b1;
  assign first_ok  = (in_first != '0) && (first_ext <= eff_len);
  assign last_ok   = (in_last != '0) && (last_ext <= eff_len);

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // Sequencer next-state logic
  always_comb begin
    state_nxt      = state_r;
    rd_idx_nxt     = rd_idx_r;
    pend_idx_nxt   = pend_idx_r;
    pend_nxt       = pend_r;
    last_idx_nxt   = last_idx_r;
    v_nxt          = v_r;
    found_nxt      = found_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_word_nxt   = out_word_r;
    out_found_nxt  = out_found_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    rd_en          = 1'b0;
    rd_addr        = rd_idx_r[AW-1:0];
    wr_en          = 1'b0;
    wr_addr        = first_m1[AW-1:0];
    issue          = 1'b0;
    move           = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          v_nxt        = in_value;
          rd_idx_nxt   = first_m1;
          last_idx_nxt = last_m1;
          pend_nxt     = 1'b0;
          case (in_kind)
            KIND_LOAD: begin
              if (first_ok) begin
                wr_en = 1'b1;
              end else begin
                state_nxt = S_ERR;
              end
            end
            KIND_READ: begin
              if (first_ok) begin
                rd_en     = 1'b1;
                rd_addr   = first_m1[AW-1:0];
                state_nxt = S_READ_OUT;
              end else begin
                state_nxt = S_ERR;
              end
            end
            KIND_FIND: begin
              rd_idx_nxt = '0;
              state_nxt  = S_FIND;
            end
            KIND_RANGE: begin
              if (first_ok && last_ok && (in_first <= in_last)) begin
                state_nxt = S_RANGE;
              end else begin
                state_nxt = S_ERR;
              end
            end
            default: state_nxt = S_ERR;
          endcase
        end
      end

      S_READ_OUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_word_nxt   = mem_q_r;
          out_found_nxt  = '0;
          out_status_nxt = 1'b0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      // One read issued and one compare done per cycle
      S_FIND: begin
        issue        = (rd_idx_r < eff_len);
        rd_en        = issue;
        rd_idx_nxt   = issue ? (rd_idx_r + 1'b1) : rd_idx_r;
        pend_nxt     = issue;
        pend_idx_nxt = rd_idx_r;
        if (pend_r && (mem_q_r == v_r)) begin
          found_nxt = POS_W'(pend_idx_r + 1'b1);
          state_nxt = S_FIND_OUT;
        end else if (!issue && !pend_r) begin
          found_nxt = '0;
          state_nxt = S_FIND_OUT;
        end
      end

      S_FIND_OUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_word_nxt   = '0;
          out_found_nxt  = found_r;
          out_status_nxt = 1'b0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      // Read ahead one word; the read data holds until the output takes it
      S_RANGE: begin
        move  = pend_r && out_free;
        issue = (!pend_r || move) && (rd_idx_r <= last_idx_r);
        rd_en = issue;
        if (issue) begin
          rd_idx_nxt   = rd_idx_r + 1'b1;
          pend_idx_nxt = rd_idx_r;
          pend_nxt     = 1'b1;
        end else if (move) begin
          pend_nxt = 1'b0;
        end
        if (move) begin
          out_valid_nxt  = 1'b1;
          out_word_nxt   = mem_q_r;
          out_found_nxt  = '0;
          out_status_nxt = 1'b0;
          out_last_nxt   = (pend_idx_r == last_idx_r);
          if (pend_idx_r == last_idx_r) begin
            state_nxt = S_IDLE;
          end
        end
      end

      S_ERR: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_word_nxt   = '0;
          out_found_nxt  = '0;
          out_status_nxt = 1'b1;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // State, control and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      used_len_r  <= USED_LENGTH_RST;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr && (cfg_paddr[2] == REG_USED_LENGTH)) begin
        used_len_r <= cfg_pwdata[POS_W-1:0];
      end
    end
    rd_idx_r     <= rd_idx_nxt;
    pend_idx_r   <= pend_idx_nxt;
    last_idx_r   <= last_idx_nxt;
    v_r          <= v_nxt;
    found_r      <= found_nxt;
    out_word_r   <= out_word_nxt;
    out_found_r  <= out_found_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[wr_addr] <= in_value;
    end
    if (rd_en) begin
      mem_q_r <= table_mem[rd_addr];
    end
  end

  // Configuration access
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_USED_LENGTH) ? CFG_DW'(used_len_r) : '0;

  // Result stream
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_found_r, out_word_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  // Error results carry no word and no position
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> (out_tdata == '0) && out_tlast)
    else $error("error result with non-zero payload");

  // A find hit is always a single, good result
  a_found_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[38:32] != '0) |-> out_tlast && !out_tuser)
    else $error("find result not final or flagged as error");

  // The find walk never runs past the effective length
  a_find_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIND) |-> (rd_idx_r <= eff_len))
    else $error("find index past the effective length");

  // Range read-ahead never overruns the end of the range
  a_range_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RANGE) && pend_r |-> (pend_idx_r <= last_idx_r))
    else $error("range word beyond the end position");

  // Any non-load query blocks the input in the cycle after it is accepted
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser != KIND_LOAD) |=> !in_tready)
    else $error("input accepted while a query is in flight");
`endif

endmodule

// ----- bench/tb_indexed_table_query_engine.sv -----
`timescale 1ns / 100ps
// Self-checking bench for indexed_table_query_engine: loads, reads, finds and range dumps
// over the stream ports, checked against an in-bench model. Depends on itq_pkg and the RTL.
module tb_indexed_table_query_engine;
  import itq_pkg::*;

  localparam int DEPTH        = ITQ_TABLE_DEPTH;
  localparam int TAIL_CYCLES  = 100;   // covers a full find walk plus lead-in
  localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
  localparam int STUCK_LIMIT  = 4000;  // cycles with no transaction at all
  localparam int PHASE_ITEMS  = 6;
  localparam logic [CFG_AW-1:0] LEN_ADDR = CFG_AW'(4 * int'(REG_USED_LENGTH));

  typedef struct packed {
    kind_t             kind;
    logic [POS_W-1:0]  first_pos;
    logic [POS_W-1:0]  last_pos;
    logic [WORD_W-1:0] value;
  } query_t;

  typedef struct packed {
    logic [WORD_W-1:0] word_out;
    logic [POS_W-1:0]  found_pos;
    logic              status;
    logic              last_flag;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [KIND_W-1:0]      in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;
  logic                   cfg_psel = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0]      cfg_paddr = '0;
  logic [CFG_DW-1:0]      cfg_pwdata = '0;
  logic [CFG_DW-1:0]      cfg_prdata;
  logic                   cfg_pready;

  indexed_table_query_engine dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Pending queries, expected answers, and the bench copy of the block state
  query_t            pending_queries[$];
  answer_t           expected_answers[$];
  logic [WORD_W-1:0] table_model[DEPTH];
  logic [POS_W-1:0]  len_model = USED_LENGTH_RST;

  // Generator-side mirror, used only to choose find values and bounds
  logic [WORD_W-1:0] gen_table[DEPTH];
  int unsigned       gen_len = DEPTH;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_req = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned hold_count = 0;

  int unsigned mismatch_count = 0;
  int unsigned answers_checked = 0;
  int unsigned kind_count[4] = '{0, 0, 0, 0};
  int unsigned stuck_cycles = 0;

  // Clock
  initial begin
    forever #2 clk = ~clk;
  end

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("[%0t] %s", $realtime, msg);
  endtask

  // Works out the answers to one accepted query and updates the table copy
  function automatic void predict_query(input query_t q);
    int unsigned eff;
    int unsigned a;
    int unsigned b;
    logic        a_ok;
    logic        b_ok;
    answer_t     ans;
    eff  = (len_model < DEPTH) ? len_model : DEPTH;
    a    = q.first_pos;
    b    = q.last_pos;
    a_ok = (a >= 1) && (a <= eff);
    b_ok = (b >= 1) && (b <= eff);
    ans  = '{word_out: '0, found_pos: '0, status: 1'b1, last_flag: 1'b1};
    case (q.kind)
      KIND_LOAD: begin
        if (a_ok) table_model[a-1] = q.value;
        else expected_answers.push_back(ans);
      end
      KIND_READ: begin
        if (a_ok) begin
          ans.word_out = table_model[a-1];
          ans.status   = 1'b0;
        end
        expected_answers.push_back(ans);
      end
      KIND_FIND: begin
        ans.status = 1'b0;
        for (int unsigned j = 0; j < eff; j++) begin
          if (table_model[j] == q.value) begin
            ans.found_pos = POS_W'(j + 1);
            break;
          end
        end
        expected_answers.push_back(ans);
      end
      default: begin
        if (!a_ok || !b_ok || a > b) begin
          expected_answers.push_back(ans);
        end else begin
          for (int unsigned j = a - 1; j < b; j++) begin
            ans.word_out  = table_model[j];
            ans.status    = 1'b0;
            ans.last_flag = (j + 1 == b);
            expected_answers.push_back(ans);
          end
        end
      end
    endcase
  endfunction

  // Queues one query and keeps the generator mirror in step for loads
  task automatic queue_query(input kind_t k, input int unsigned a, input int unsigned b,
                             input logic [WORD_W-1:0] v);
    query_t q;
    q = '{kind: k, first_pos: POS_W'(a), last_pos: POS_W'(b), value: v};
    if (k == KIND_LOAD && a >= 1 && a <= gen_len) gen_table[a-1] = v;
    pending_queries.push_back(q);
  endtask

  // Word values: extremes, a small pool that forces duplicates, and noise
  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3, 4: return 32'($urandom_range(3));
      default: return $urandom();
    endcase
  endfunction

  // One random query once every entry has been written
  task automatic queue_random_query();
    kind_t       k;
    int unsigned a;
    int unsigned b;
    int unsigned pick;
    logic [WORD_W-1:0] v;
    k    = kind_t'($urandom_range(3));
    a    = $urandom_range(DEPTH, 1);
    b    = $urandom_range(DEPTH, 1);
    v    = pick_word();
    pick = $urandom_range(99);
    if (k == KIND_FIND && pick < 60)
      v = gen_table[$urandom_range((gen_len < DEPTH ? gen_len : DEPTH) - 1)];
    if (k == KIND_RANGE) begin
      if (pick < 5) begin
        a = 1;
        b = DEPTH;
      end else if (pick < 85) begin
        b = a + $urandom_range(7);
        if (b > DEPTH) b = DEPTH;
      end
    end
    queue_query(k, a, b, v);
  endtask

  // Register write with readback, only while the block is quiet
  task automatic set_used_length(input int unsigned len);
    logic [CFG_DW-1:0] rd;
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= LEN_ADDR;
    cfg_pwdata  <= CFG_DW'(len);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    len_model = POS_W'(len);
    gen_len   = len;
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rd = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (rd !== CFG_DW'(len))
      note_mismatch($sformatf("used_length readback: expected %0d, got %0d", len, rd));
  endtask

  // Waits for every query to go in and every answer to come out, then a tail
  task automatic wait_quiet();
    while (pending_queries.size() != 0 || in_tvalid || expected_answers.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Query driver
  always @(posedge clk) begin : drive_queries
    query_t taken;
    query_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        taken.kind      = kind_t'(in_tuser);
        taken.first_pos = in_tdata[6:0];
        taken.last_pos  = in_tdata[13:7];
        taken.value     = in_tdata[45:14];
        predict_query(taken);
        kind_count[in_tuser]++;
      end
      if (pending_queries.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_queries.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= nxt.kind;
        in_tdata  <= {2'b00, nxt.value, nxt.last_pos, nxt.first_pos};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Answer monitor and receiver back-pressure
  always @(posedge clk) begin : check_answers
    answer_t got;
    answer_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = '{word_out: out_tdata[31:0], found_pos: out_tdata[38:32],
                status: out_tuser, last_flag: out_tlast};
        answers_checked++;
        if (expected_answers.size() == 0) begin
          note_mismatch($sformatf("unexpected answer word=%h found=%0d status=%b last=%b",
                                  got.word_out, got.found_pos, got.status, got.last_flag));
        end else begin
          want = expected_answers.pop_front();
          if (got !== want)
            note_mismatch($sformatf({"answer: expected word=%h found=%0d status=%b last=%b,",
                                     " got word=%h found=%0d status=%b last=%b"},
                                    want.word_out, want.found_pos, want.status,
                                    want.last_flag, got.word_out, got.found_pos,
                                    got.status, got.last_flag));
        end
      end
      // long hold-off once, then random stalls
      if (hold_req && !hold_done) begin
        out_tready <= 1'b0;
        hold_count <= hold_count + 1;
        if (hold_count == HOLD_CYCLES - 1) hold_done <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog on cycles with no transaction anywhere
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel || !rst_n) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", STUCK_LIMIT);
      $display("indexed_table_query_engine: mismatch");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Stimulus sequence
  initial begin : run_test
    static int unsigned phase_len[5]   = '{64, 37, 64, 12, 1};
    static int unsigned phase_send[5]  = '{0, 66, 0, 19, 19};
    static int unsigned phase_stall[5] = '{0, 0, 66, 19, 19};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, full length after reset: extremes of words and positions
    queue_query(KIND_LOAD, 1, 1, 32'h8000_0000);
    queue_query(KIND_LOAD, 2, 1, 32'h7FFF_FFFF);
    queue_query(KIND_LOAD, 3, 1, 32'h0000_0000);
    queue_query(KIND_LOAD, 4, 1, 32'hFFFF_FFFF);
    queue_query(KIND_LOAD, 63, 1, 32'h0000_0001);
    queue_query(KIND_LOAD, 64, 1, 32'hA5A5_5A5A);
    queue_query(KIND_READ, 1, 1, '0);
    queue_query(KIND_READ, 2, 1, '0);
    queue_query(KIND_READ, 64, 1, '0);
    queue_query(KIND_RANGE, 1, 4, '0);
    queue_query(KIND_RANGE, 63, 64, '0);
    queue_query(KIND_RANGE, 64, 64, '0);
    queue_query(KIND_RANGE, 4, 3, '0);      // reversed range, answered with an error
    queue_query(KIND_FIND, 1, 1, 32'h7FFF_FFFF);
    queue_query(KIND_FIND, 1, 1, 32'hFFFF_FFFF);
    queue_query(KIND_FIND, 1, 1, 32'h8000_0000);
    wait_quiet();

    // Directed, one entry in use: finds, and out-of-range load, read and range
    set_used_length(1);
    queue_query(KIND_FIND, 1, 1, 32'h1234_5678);  // not present
    queue_query(KIND_FIND, 1, 1, 32'h8000_0000);
    queue_query(KIND_READ, 1, 1, '0);
    queue_query(KIND_READ, 2, 1, '0);
    queue_query(KIND_LOAD, 2, 1, 32'hDEAD_BEEF);  // rejected, must not store
    queue_query(KIND_RANGE, 1, 2, '0);
    queue_query(KIND_RANGE, 1, 1, '0);
    queue_query(KIND_LOAD, 64, 1, 32'h0BAD_F00D);
    wait_quiet();

    // Back to full length; rejected load left entry 2 alone, then fill every entry
    set_used_length(64);
    queue_query(KIND_READ, 2, 1, '0);
    for (int unsigned p = 1; p <= DEPTH; p++)
      queue_query(KIND_LOAD, p, 1, pick_word());
    wait_quiet();

    // Random phases over lengths and idling patterns
    for (int unsigned ph = 0; ph < 5; ph++) begin
      set_used_length(phase_len[ph]);
      send_idle_pct  = phase_send[ph];
      recv_stall_pct = phase_stall[ph];
      if (ph == 2) hold_req = 1'b1;
      for (int unsigned n = 0; n < PHASE_ITEMS; n++)
        queue_random_query();
      wait_quiet();
    end

    $display("covered %0d queries (load %0d, read %0d, find %0d, range %0d), %0d answers",
             kind_count[0] + kind_count[1] + kind_count[2] + kind_count[3], kind_count[0],
             kind_count[1], kind_count[2], kind_count[3], answers_checked);
    $display("table lengths 64, 1, 37, 12; one %0d-cycle receiver hold-off", HOLD_CYCLES);
    if (mismatch_count == 0 && expected_answers.size() == 0) begin
      $display("indexed_table_query_engine: match");
    end else begin
      $display("%0d mismatches, %0d answers outstanding", mismatch_count,
               expected_answers.size());
      $display("indexed_table_query_engine: mismatch");
    end
    $finish;
  end

endmodule
